### hdl/m4inv_pkg.sv
// Shared types and constants for the 4x4 full-pivot matrix inverter.
`timescale 1ns / 1ps

package m4inv_pkg;

    localparam int DIM           = 4;
    localparam int IDX_W         = 2;
    localparam int ADDR_W        = 4;
    localparam int DATA_W        = 32;
    localparam int FRAC_BITS_DEF = 16;

    // write data source for the work matrix
    typedef enum logic [2:0] {
        WS_IN,
        WS_RDA,
        WS_TMP,
        WS_ONE,
        WS_ZERO,
        WS_SCALE,
        WS_SUB
    } t_wsel;

    // second multiplier operand
    typedef enum logic {
        MS_PINV,
        MS_FACT
    } t_msel;

    typedef struct packed {
        logic [ADDR_W-1:0] rd_a_addr;
        logic [ADDR_W-1:0] rd_b_addr;
        logic              wr_en;
        logic [ADDR_W-1:0] wr_addr;
        t_wsel             wr_sel;
        logic              big_clr;
        logic              big_upd;
        logic              tmp_ld;
        logic              div_start;
        logic              f_ld;
        logic              mul_en;
        t_msel             mul_sel;
        logic              out_ld;
        logic              out_zero;
        logic [ADDR_W-1:0] out_idx;
    } t_dp_cmd;

    typedef struct packed {
        logic mag_ge;
        logic rda_zero;
        logic div_done;
    } t_dp_stat;

endpackage

### hdl/m4inv_dp.sv
// Datapath: work matrix memory, pivot search compare, divider, multiplier, output register.
`timescale 1ns / 1ps

module m4inv_dp #(
    parameter int FRAC_BITS = m4inv_pkg::FRAC_BITS_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  m4inv_pkg::t_dp_cmd              i_cmd,
    input  logic [m4inv_pkg::DATA_W-1:0]    i_in_value,
    output m4inv_pkg::t_dp_stat             o_stat,
    output logic [m4inv_pkg::IDX_W-1:0]     o_out_row,
    output logic [m4inv_pkg::IDX_W-1:0]     o_out_col,
    output logic [m4inv_pkg::DATA_W-1:0]    o_out_value,
    output logic                            o_out_sing,
    output logic                            o_out_eom
);

    localparam int NW    = (2*FRAC_BITS+2 > 34) ? 2*FRAC_BITS+2 : 34;
    localparam int CW    = $clog2(NW+1);
    localparam int DEPTH = m4inv_pkg::DIM * m4inv_pkg::DIM;
    localparam logic [NW-1:0] NUM_ONE = NW'(1) << (2*FRAC_BITS);
    localparam logic [31:0] ONE = 32'(1) << FRAC_BITS;
    localparam logic signed [63:0] HALF = 64'sd1 <<< (FRAC_BITS-1);

    logic [31:0] mem [DEPTH];
    logic [31:0] r_rd_a, r_rd_b, r_tmp, r_fact, r_pinv, r_b2;
    logic [32:0] r_big;
    logic signed [63:0] r_prod;

    logic [32:0] r_dsor, r_rem;
    logic [NW-1:0] r_num, r_quo;
    logic [CW-1:0] r_dcnt;
    logic r_dbusy, r_ddone, r_dneg;

    logic [31:0] r_out_value;
    logic [1:0]  r_out_row, r_out_col;
    logic        r_out_sing, r_out_eom;

    logic [32:0] mag_a;
    logic [33:0] rem_sh;
    logic        q_bit;
    logic [63:0] qw;
    logic [31:0] pinv_c;
    logic signed [63:0] p_rnd, p_shr;
    logic [31:0] scaled;
    logic signed [32:0] diff;
    logic [31:0] sub_sat;
    logic [31:0] wdata;

    assign mag_a = r_rd_a[31] ? (33'd0 - {1'b1, r_rd_a}) : {1'b0, r_rd_a};

    // one quotient bit per cycle
    assign rem_sh = {r_rem, r_num[NW-1]};
    assign q_bit  = (rem_sh >= {1'b0, r_dsor});

    always_comb begin
        qw = 64'(r_quo);
        if (qw > 64'h8000_0000) begin
            qw = 64'h8000_0000;
        end
        if (!r_dneg) begin
            pinv_c = (qw > 64'h7FFF_FFFF) ? 32'h7FFF_FFFF : qw[31:0];
        end else begin
            pinv_c = 32'd0 - qw[31:0];
        end
    end

    // round half up, floor shift, saturate
    always_comb begin
        p_rnd = r_prod + HALF;
        p_shr = p_rnd >>> FRAC_BITS;
        if (p_shr > 64'sh7FFF_FFFF) begin
            scaled = 32'h7FFF_FFFF;
        end else if (p_shr < -64'sh8000_0000) begin
            scaled = 32'h8000_0000;
        end else begin
            scaled = p_shr[31:0];
        end
        diff = $signed({r_b2[31], r_b2}) - $signed({scaled[31], scaled});
        if (diff[32] != diff[31]) begin
            sub_sat = diff[32] ? 32'h8000_0000 : 32'h7FFF_FFFF;
        end else begin
            sub_sat = diff[31:0];
        end
    end

    always_comb begin
        unique case (i_cmd.wr_sel)
            m4inv_pkg::WS_IN:    wdata = i_in_value;
            m4inv_pkg::WS_RDA:   wdata = r_rd_a;
            m4inv_pkg::WS_TMP:   wdata = r_tmp;
            m4inv_pkg::WS_ONE:   wdata = ONE;
            m4inv_pkg::WS_ZERO:  wdata = 32'd0;
            m4inv_pkg::WS_SCALE: wdata = scaled;
            m4inv_pkg::WS_SUB:   wdata = sub_sat;
            default:             wdata = 32'd0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_en) begin
            mem[i_cmd.wr_addr] <= wdata;
        end
        r_rd_a <= mem[i_cmd.rd_a_addr];
        r_rd_b <= mem[i_cmd.rd_b_addr];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.big_clr) begin
            r_big <= 33'd0;
        end else if (i_cmd.big_upd) begin
            r_big <= mag_a;
        end
        if (i_cmd.tmp_ld) r_tmp <= r_rd_b;
        if (i_cmd.f_ld)   r_fact <= r_rd_a;
        if (i_cmd.mul_en) begin
            r_prod <= $signed(r_rd_a) *
                      $signed((i_cmd.mul_sel == m4inv_pkg::MS_PINV) ? r_pinv : r_fact);
            r_b2   <= r_rd_b;
        end
        if (r_ddone) r_pinv <= pinv_c;
        if (i_cmd.out_ld) begin
            r_out_value <= i_cmd.out_zero ? 32'd0 : r_rd_a;
            r_out_row   <= i_cmd.out_idx[3:2];
            r_out_col   <= i_cmd.out_idx[1:0];
            r_out_sing  <= i_cmd.out_zero;
            r_out_eom   <= (i_cmd.out_idx == 4'(DEPTH-1));
        end
    end

    // restoring reciprocal divider
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dbusy <= 1'b0;
            r_ddone <= 1'b0;
        end else begin
            r_ddone <= 1'b0;
            if (i_cmd.div_start) begin
                r_dsor  <= mag_a;
                r_dneg  <= r_rd_a[31];
                r_num   <= NUM_ONE + NW'(mag_a >> 1);
                r_rem   <= 33'd0;
                r_quo   <= '0;
                r_dcnt  <= CW'(NW);
                r_dbusy <= 1'b1;
            end else if (r_dbusy) begin
                r_rem  <= q_bit ? 33'(rem_sh - {1'b0, r_dsor}) : rem_sh[32:0];
                r_quo  <= {r_quo[NW-2:0], q_bit};
                r_num  <= r_num << 1;
                r_dcnt <= r_dcnt - 1'b1;
                if (r_dcnt == CW'(1)) begin
                    r_dbusy <= 1'b0;
                    r_ddone <= 1'b1;
                end
            end
        end
    end

    assign o_stat.mag_ge   = (mag_a >= r_big);
    assign o_stat.rda_zero = (r_rd_a == 32'd0);
    assign o_stat.div_done = r_ddone;

    assign o_out_row   = r_out_row;
    assign o_out_col   = r_out_col;
    assign o_out_value = r_out_value;
    assign o_out_sing  = r_out_sing;
    assign o_out_eom   = r_out_eom;

endmodule

### hdl/m4inv_ctl.sv
// Controller: sequences load, pivot rounds, swaps, column unscramble and result output.
`timescale 1ns / 1ps

module m4inv_ctl (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [1:0]             i_in_row,
    input  logic [1:0]             i_in_col,
    input  logic                   s_tlast,
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output m4inv_pkg::t_dp_cmd     o_cmd,
    input  m4inv_pkg::t_dp_stat    i_stat
);

    typedef enum logic [4:0] {
        S_IDLE, S_SRCH, S_SWAP_RD, S_SWAP_W1, S_SWAP_W2, S_PIV_RD, S_PIV_CHK,
        S_DIV_WAIT, S_SET_ONE, S_SC_RD, S_SC_MUL, S_SC_WR, S_EL_J, S_EL_FLD,
        S_EL_RD, S_EL_MUL, S_EL_WR, S_CS_CHK, S_OUT_RD, S_OUT_LD, S_OUT_WAIT
    } t_state;

    t_state     r_state;
    logic [4:0] r_n;
    logic [1:0] r_k, r_j, r_round, r_cs;
    logic [3:0] r_used;
    logic [1:0] r_prow, r_pcol;
    logic [1:0] r_rowrec [4];
    logic [1:0] r_colrec [4];
    logic       r_swap_col, r_sing, r_mvalid;

    logic [3:0] e;
    logic       hit;
    logic [1:0] sel_row, sel_col;
    logic [1:0] sw_a, sw_b;
    logic       in_acc;

    assign in_acc  = s_tvalid && s_tready;
    assign s_tready = (r_state == S_IDLE);
    assign m_tvalid = r_mvalid;

    assign e   = 4'(r_n - 5'd1);
    assign hit = (r_state == S_SRCH) && (r_n != 5'd0) &&
                 !r_used[e[3:2]] && !r_used[e[1:0]] && i_stat.mag_ge;
    assign sel_row = hit ? e[3:2] : r_prow;
    assign sel_col = hit ? e[1:0] : r_pcol;
    assign sw_a = r_rowrec[r_cs];
    assign sw_b = r_colrec[r_cs];

    always_comb begin
        o_cmd = '0;
        o_cmd.wr_sel  = m4inv_pkg::WS_IN;
        o_cmd.mul_sel = m4inv_pkg::MS_PINV;
        o_cmd.big_upd = hit;
        o_cmd.out_idx = r_n[3:0];
        o_cmd.out_zero = r_sing;
        unique case (r_state)
            S_IDLE: begin
                o_cmd.wr_en   = in_acc;
                o_cmd.wr_addr = {i_in_row, i_in_col};
            end
            S_SRCH: begin
                o_cmd.rd_a_addr = r_n[3:0];
                o_cmd.big_clr   = (r_n == 5'd0);
            end
            S_SWAP_RD: begin
                o_cmd.rd_a_addr = r_swap_col ? {r_k, sw_a} : {r_prow, r_k};
                o_cmd.rd_b_addr = r_swap_col ? {r_k, sw_b} : {r_pcol, r_k};
            end
            S_SWAP_W1: begin
                o_cmd.tmp_ld  = 1'b1;
                o_cmd.wr_en   = 1'b1;
                o_cmd.wr_sel  = m4inv_pkg::WS_RDA;
                o_cmd.wr_addr = r_swap_col ? {r_k, sw_b} : {r_pcol, r_k};
            end
            S_SWAP_W2: begin
                o_cmd.wr_en   = 1'b1;
                o_cmd.wr_sel  = m4inv_pkg::WS_TMP;
                o_cmd.wr_addr = r_swap_col ? {r_k, sw_a} : {r_prow, r_k};
            end
            S_PIV_RD:  o_cmd.rd_a_addr = {r_pcol, r_pcol};
            S_PIV_CHK: o_cmd.div_start = !i_stat.rda_zero;
            S_DIV_WAIT: ;
            S_SET_ONE: begin
                o_cmd.wr_en   = 1'b1;
                o_cmd.wr_sel  = m4inv_pkg::WS_ONE;
                o_cmd.wr_addr = {r_pcol, r_pcol};
            end
            S_SC_RD:  o_cmd.rd_a_addr = {r_pcol, r_k};
            S_SC_MUL: o_cmd.mul_en = 1'b1;
            S_SC_WR: begin
                o_cmd.wr_en   = 1'b1;
                o_cmd.wr_sel  = m4inv_pkg::WS_SCALE;
                o_cmd.wr_addr = {r_pcol, r_k};
            end
            S_EL_J: o_cmd.rd_a_addr = {r_j, r_pcol};
            S_EL_FLD: begin
                o_cmd.f_ld    = 1'b1;
                o_cmd.wr_en   = 1'b1;
                o_cmd.wr_sel  = m4inv_pkg::WS_ZERO;
                o_cmd.wr_addr = {r_j, r_pcol};
            end
            S_EL_RD: begin
                o_cmd.rd_a_addr = {r_pcol, r_k};
                o_cmd.rd_b_addr = {r_j, r_k};
            end
            S_EL_MUL: begin
                o_cmd.mul_en  = 1'b1;
                o_cmd.mul_sel = m4inv_pkg::MS_FACT;
            end
            S_EL_WR: begin
                o_cmd.wr_en   = 1'b1;
                o_cmd.wr_sel  = m4inv_pkg::WS_SUB;
                o_cmd.wr_addr = {r_j, r_k};
            end
            S_CS_CHK: ;
            S_OUT_RD: o_cmd.rd_a_addr = r_n[3:0];
            S_OUT_LD: o_cmd.out_ld = 1'b1;
            S_OUT_WAIT: ;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_mvalid <= 1'b0;
            r_sing   <= 1'b0;
            r_used   <= 4'd0;
            r_n      <= 5'd0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (in_acc && s_tlast) begin
                        r_used  <= 4'd0;
                        r_sing  <= 1'b0;
                        r_round <= 2'd0;
                        r_n     <= 5'd0;
                        r_state <= S_SRCH;
                    end
                end
                S_SRCH: begin
                    if (r_n == 5'd0) begin
                        r_prow <= 2'd0;
                        r_pcol <= 2'd0;
                    end else begin
                        r_prow <= sel_row;
                        r_pcol <= sel_col;
                    end
                    if (r_n == 5'd16) begin
                        r_used[sel_col]    <= 1'b1;
                        r_rowrec[r_round]  <= sel_row;
                        r_colrec[r_round]  <= sel_col;
                        r_swap_col <= 1'b0;
                        r_k        <= 2'd0;
                        r_state    <= (sel_row != sel_col) ? S_SWAP_RD : S_PIV_RD;
                    end else begin
                        r_n <= r_n + 5'd1;
                    end
                end
                S_SWAP_RD: r_state <= S_SWAP_W1;
                S_SWAP_W1: r_state <= S_SWAP_W2;
                S_SWAP_W2: begin
                    r_k <= r_k + 2'd1;
                    if (r_k != 2'd3) begin
                        r_state <= S_SWAP_RD;
                    end else if (!r_swap_col) begin
                        r_state <= S_PIV_RD;
                    end else if (r_cs == 2'd0) begin
                        r_n     <= 5'd0;
                        r_state <= S_OUT_RD;
                    end else begin
                        r_cs    <= r_cs - 2'd1;
                        r_state <= S_CS_CHK;
                    end
                end
                S_PIV_RD: r_state <= S_PIV_CHK;
                S_PIV_CHK: begin
                    if (i_stat.rda_zero) begin
                        r_sing  <= 1'b1;
                        r_n     <= 5'd0;
                        r_state <= S_OUT_RD;
                    end else begin
                        r_state <= S_DIV_WAIT;
                    end
                end
                S_DIV_WAIT: if (i_stat.div_done) r_state <= S_SET_ONE;
                S_SET_ONE: begin
                    r_k     <= 2'd0;
                    r_state <= S_SC_RD;
                end
                S_SC_RD:  r_state <= S_SC_MUL;
                S_SC_MUL: r_state <= S_SC_WR;
                S_SC_WR: begin
                    r_k <= r_k + 2'd1;
                    if (r_k == 2'd3) begin
                        r_j     <= 2'd0;
                        r_state <= S_EL_J;
                    end else begin
                        r_state <= S_SC_RD;
                    end
                end
                S_EL_J: begin
                    if (r_j != r_pcol) begin
                        r_state <= S_EL_FLD;
                    end else if (r_j != 2'd3) begin
                        r_j <= r_j + 2'd1;
                    end else if (r_round == 2'd3) begin
                        r_cs    <= 2'd3;
                        r_state <= S_CS_CHK;
                    end else begin
                        r_round <= r_round + 2'd1;
                        r_n     <= 5'd0;
                        r_state <= S_SRCH;
                    end
                end
                S_EL_FLD: begin
                    r_k     <= 2'd0;
                    r_state <= S_EL_RD;
                end
                S_EL_RD:  r_state <= S_EL_MUL;
                S_EL_MUL: r_state <= S_EL_WR;
                S_EL_WR: begin
                    r_k <= r_k + 2'd1;
                    if (r_k != 2'd3) begin
                        r_state <= S_EL_RD;
                    end else if (r_j != 2'd3) begin
                        r_j     <= r_j + 2'd1;
                        r_state <= S_EL_J;
                    end else if (r_round == 2'd3) begin
                        r_cs    <= 2'd3;
                        r_state <= S_CS_CHK;
                    end else begin
                        r_round <= r_round + 2'd1;
                        r_n     <= 5'd0;
                        r_state <= S_SRCH;
                    end
                end
                S_CS_CHK: begin
                    if (sw_a != sw_b) begin
                        r_swap_col <= 1'b1;
                        r_k        <= 2'd0;
                        r_state    <= S_SWAP_RD;
                    end else if (r_cs == 2'd0) begin
                        r_n     <= 5'd0;
                        r_state <= S_OUT_RD;
                    end else begin
                        r_cs <= r_cs - 2'd1;
                    end
                end
                S_OUT_RD: r_state <= S_OUT_LD;
                S_OUT_LD: begin
                    r_mvalid <= 1'b1;
                    r_state  <= S_OUT_WAIT;
                end
                S_OUT_WAIT: begin
                    if (m_tready) begin
                        r_mvalid <= 1'b0;
                        if (r_n == 5'd15) begin
                            r_state <= S_IDLE;
                        end else begin
                            r_n     <= r_n + 5'd1;
                            r_state <= S_OUT_RD;
                        end
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

`ifndef SYNTH
    a_valid_in_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_mvalid |-> (r_state == S_OUT_WAIT))
        else $error("result valid outside output wait");
    a_no_load_while_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(s_tready && r_mvalid))
        else $error("input ready while result pending");
    a_last_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && s_tlast) |=> (r_state == S_SRCH) && (r_used == 4'd0))
        else $error("last item did not start inversion");
    a_pivot_unused: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SRCH && r_n == 5'd16) |=> $countones(r_used) == 32'(r_round) + 1)
        else $error("pivot column use count wrong");
`endif

endmodule

### hdl/matrix4_inverse_full_pivot.sv
// Top level of the 4x4 Gauss-Jordan full-pivot matrix inverter.
`timescale 1ns / 1ps

// Load the matrix as 16 items on the s_ channel, one element each, tagged
// by row and column, signed Q16.16 by default. The item with tlast stores
// its element and starts the inversion; no input is taken until all 16
// results are out. Each of the four pivot rounds scans the 16 entries of
// the work memory, swaps rows if needed, reads the pivot and runs a
// one-bit-per-cycle restoring divider for its reciprocal, scales the
// pivot row and eliminates the three other rows; a last pass undoes the
// column permutation. The time per inversion is set by the divider and
// the read, multiply, write loop of scaling and elimination. Results
// leave in row-major order, each held until it is taken; tuser flags a
// zero pivot (all values then zero) and tlast marks the sixteenth
// result. Products round half up and every multiply, subtract and
// reciprocal saturates to 32 bits.
module matrix4_inverse_full_pivot #(
    parameter int FRAC_BITS = m4inv_pkg::FRAC_BITS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,   // row[1:0], col[3:2], value[35:4], zero[39:36]
    input  logic        s_tlast,   // last element, starts inversion
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // out_row[1:0], out_col[3:2], out_value[35:4], zero[39:36]
    output logic        m_tuser,   // singular
    output logic        m_tlast    // end_of_matrix
);

    m4inv_pkg::t_dp_cmd  cmd;
    m4inv_pkg::t_dp_stat stat;
    logic [1:0]  out_row, out_col;
    logic [31:0] out_value;

    m4inv_ctl u_ctl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .i_in_row (s_tdata[1:0]),
        .i_in_col (s_tdata[3:2]),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .o_cmd    (cmd),
        .i_stat   (stat)
    );

    m4inv_dp #(
        .FRAC_BITS (FRAC_BITS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .i_in_value  (s_tdata[35:4]),
        .o_stat      (stat),
        .o_out_row   (out_row),
        .o_out_col   (out_col),
        .o_out_value (out_value),
        .o_out_sing  (m_tuser),
        .o_out_eom   (m_tlast)
    );

    assign m_tdata = {4'd0, out_value, out_col, out_row};

endmodule

### verif/matrix4_inverse_full_pivot_tb.sv
// Testbench for the 4x4 full-pivot matrix inverter: directed, random and backpressure items.
`timescale 1ns / 1ps

module matrix4_inverse_full_pivot_tb;

    localparam int FRAC      = m4inv_pkg::FRAC_BITS_DEF;
    localparam int DIM       = m4inv_pkg::DIM;
    localparam int N_ELEM    = DIM * DIM;
    localparam int CYC_LIMIT = 600000;
    localparam int DRAIN_CYC = 600;   // one inversion plus slack

    typedef struct {
        logic [1:0]  row;
        logic [1:0]  col;
        logic [31:0] value;
        logic        sing;
        logic        eom;
    } t_inv_elem;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [39:0] s_tdata = '0;    // row[1:0], col[3:2], value[35:4], zero[39:36]
    logic        s_tlast = 1'b0;  // last element
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [39:0] m_tdata;         // out_row[1:0], out_col[3:2], out_value[35:4], zero[39:36]
    logic        m_tuser;         // singular
    logic        m_tlast;         // end_of_matrix

    // predictor state
    int          work_mat [N_ELEM];
    logic [1:0]  use_cnt  [DIM];
    int          prow_rec [DIM];
    int          pcol_rec [DIM];
    bit          sing_seen;

    t_inv_elem   inverse_q [$];
    int          err_cnt = 0;
    int          items_sent = 0;
    int          inversions = 0;
    int          singular_cnt = 0;
    int          results_seen = 0;
    int          cycle = 0;
    int          hold_until = 0;
    int          snd_idle = 32;
    int          rcv_idle = 55;

    matrix4_inverse_full_pivot dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .s_tlast (s_tlast),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata),
        .m_tuser (m_tuser),
        .m_tlast (m_tlast)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // ---------------- fixed-point arithmetic ----------------
    function automatic int sat32(longint x);
        if (x > 64'sd2147483647) return 32'sh7fffffff;
        if (x < -64'sd2147483648) return 32'sh80000000;
        return int'(x);
    endfunction

    // round half up, then floor by FRAC bits
    function automatic int qmul(int a, int b);
        longint p;
        p = longint'(a) * longint'(b) + (64'sd1 <<< (FRAC - 1));
        return sat32(p >>> FRAC);
    endfunction

    // 2^(2*FRAC)/p, ties away from zero
    function automatic int qrecip(int p);
        longint m;
        longint q;
        m = (p < 0) ? -longint'(p) : longint'(p);
        q = ((64'sd1 <<< (2 * FRAC)) + m / 2) / m;
        if (q > 64'sh80000000) q = 64'sh80000000;
        if (p > 0) return (q > 64'sh7fffffff) ? 32'sh7fffffff : int'(q);
        return int'(-q);
    endfunction

    function automatic longint mag(int v);
        return (v < 0) ? -longint'(v) : longint'(v);
    endfunction

    // in-place Gauss-Jordan with full pivoting on work_mat
    task automatic gj_invert();
        int     pr, pc, pinv, f, t;
        longint big;
        for (int i = 0; i < DIM; i++) use_cnt[i] = 2'd0;
        sing_seen = 1'b0;
        for (int r = 0; r < DIM; r++) begin
            pr = 0;
            pc = 0;
            big = 0;
            for (int i = 0; i < DIM; i++) begin
                if (use_cnt[i] == 2'd1) continue;
                for (int k = 0; k < DIM; k++) begin
                    if (use_cnt[k] != 2'd0) continue;
                    if (mag(work_mat[i*DIM+k]) >= big) begin
                        big = mag(work_mat[i*DIM+k]);
                        pr = i;
                        pc = k;
                    end
                end
            end
            use_cnt[pc] = use_cnt[pc] + 2'd1;
            if (pr != pc) begin
                for (int k = 0; k < DIM; k++) begin
                    t = work_mat[pr*DIM+k];
                    work_mat[pr*DIM+k] = work_mat[pc*DIM+k];
                    work_mat[pc*DIM+k] = t;
                end
            end
            prow_rec[r] = pr;
            pcol_rec[r] = pc;
            if (work_mat[pc*DIM+pc] == 0) begin
                sing_seen = 1'b1;
                return;
            end
            pinv = qrecip(work_mat[pc*DIM+pc]);
            work_mat[pc*DIM+pc] = 1 << FRAC;
            for (int k = 0; k < DIM; k++)
                work_mat[pc*DIM+k] = qmul(work_mat[pc*DIM+k], pinv);
            for (int j = 0; j < DIM; j++) begin
                if (j == pc) continue;
                f = work_mat[j*DIM+pc];
                work_mat[j*DIM+pc] = 0;
                for (int k = 0; k < DIM; k++)
                    work_mat[j*DIM+k] = sat32(longint'(work_mat[j*DIM+k])
                                              - longint'(qmul(work_mat[pc*DIM+k], f)));
            end
        end
        // undo the column permutation
        for (int r = DIM - 1; r >= 0; r--) begin
            if (prow_rec[r] != pcol_rec[r]) begin
                for (int k = 0; k < DIM; k++) begin
                    t = work_mat[k*DIM+prow_rec[r]];
                    work_mat[k*DIM+prow_rec[r]] = work_mat[k*DIM+pcol_rec[r]];
                    work_mat[k*DIM+pcol_rec[r]] = t;
                end
            end
        end
    endtask

    // update the predictor for one accepted item
    task automatic predict_load(int row, int col, int value, bit last);
        t_inv_elem e;
        work_mat[row*DIM+col] = value;
        if (last) begin
            gj_invert();
            inversions++;
            if (sing_seen) singular_cnt++;
            for (int n = 0; n < N_ELEM; n++) begin
                e.row   = 2'(n / DIM);
                e.col   = 2'(n % DIM);
                e.value = sing_seen ? 32'd0 : work_mat[n];
                e.sing  = sing_seen;
                e.eom   = (n == N_ELEM - 1);
                inverse_q.push_back(e);
            end
        end
    endtask

    // ---------------- stimulus ----------------
    task automatic send_elem(int row, int col, int value, bit last);
        int gap;
        gap = 0;
        while ($urandom_range(99, 0) < snd_idle && gap < 12) gap++;
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {4'd0, value[31:0], col[1:0], row[1:0]};
        s_tlast  <= last;
        do @(posedge i_clk); while (!s_tready);
        predict_load(row, col, value, last);
        items_sent++;
    endtask

    task automatic stop_sending();
        s_tvalid <= 1'b0;
        s_tlast  <= 1'b0;
    endtask

    task automatic wait_results_drained();
        stop_sending();
        wait (inverse_q.size() == 0);
        @(posedge i_clk);
    endtask

    function automatic int rand_value();
        case ($urandom_range(9, 0))
            0, 1, 2, 3: return $urandom_range(32'h0008_0000, 0) - 32'h0004_0000;
            4:          return 0;
            5:          return 32'h7fffffff;
            6:          return 32'h80000000;
            7:          return $urandom;
            8:          return $urandom_range(6, 0) - 3;
            default:    return $urandom_range(32'h00ff_ffff, 0) - 32'h0080_0000;
        endcase
    endfunction

    // full matrix in shuffled order, last on the final element
    task automatic send_matrix(int kind);
        int order [N_ELEM];
        int v, zr, dup;
        int vals [N_ELEM];
        for (int n = 0; n < N_ELEM; n++) begin
            order[n] = n;
            vals[n] = rand_value();
        end
        order.shuffle();
        zr  = $urandom_range(DIM - 1, 0);
        dup = (zr + 1) % DIM;
        case (kind)
            1: for (int k = 0; k < DIM; k++) vals[zr*DIM+k] = 0;          // zero row
            2: for (int k = 0; k < DIM; k++) vals[dup*DIM+k] = vals[zr*DIM+k]; // equal rows
            3: for (int k = 0; k < DIM; k++)                               // diagonal of magnitude 16 to 32
                   vals[k*DIM+k] = ($urandom_range(1, 0) ? 1 : -1) * (32'h0010_0000
                                    + $urandom_range(32'h0010_0000, 0));
            default: ;
        endcase
        for (int n = 0; n < N_ELEM; n++) begin
            v = vals[order[n]];
            send_elem(order[n] / DIM, order[n] % DIM, v, n == N_ELEM - 1);
        end
    endtask

    task automatic random_block(int n_items);
        int start, upd;
        start = items_sent;
        while (items_sent - start < n_items) begin
            case ($urandom_range(9, 0))
                0, 1, 2, 3, 4: send_matrix($urandom_range(3, 0));
                5, 6, 7: begin
                    // few element updates, then invert again
                    upd = $urandom_range(4, 1);
                    for (int i = 0; i < upd; i++)
                        send_elem($urandom_range(3, 0), $urandom_range(3, 0), rand_value(),
                                  i == upd - 1);
                end
                default: begin
                    // loads with no inversion
                    send_elem($urandom_range(3, 0), $urandom_range(3, 0), rand_value(), 1'b0);
                end
            endcase
        end
    endtask

    // ---------------- tests ----------------
    task automatic test_directed();
        // signed Hadamard: many equal-magnitude ties for the pivot search
        int had [N_ELEM] = '{1, 1, 1, 1,  1, -1, 1, -1,  1, 1, -1, -1,  1, -1, -1, 1};
        for (int n = 0; n < N_ELEM; n++)
            send_elem(n / DIM, n % DIM, had[n] <<< FRAC, n == N_ELEM - 1);
        // extreme values, each followed by an inversion
        send_elem(0, 0, 32'h7fffffff, 1'b1);
        send_elem(3, 3, 32'h80000000, 1'b1);
        send_elem(2, 1, 32'h00000001, 1'b1);
        // zero column: pivot of zero, singular result
        for (int r = 0; r < DIM; r++)
            send_elem(r, 2, 0, r == DIM - 1);
        wait_results_drained();
    endtask

    task automatic test_backpressure();
        // receiver holds off; the block fills and stops taking input
        hold_until = cycle + 2500;
        send_matrix(3);
        send_elem(1, 2, rand_value(), 1'b1);
        send_elem(2, 3, rand_value(), 1'b1);
        wait_results_drained();
    endtask

    task automatic test_random();
        snd_idle = 32;
        rcv_idle = 55;
        random_block(65);
        wait_results_drained();
        snd_idle = 55;
        rcv_idle = 32;
        random_block(65);
        wait_results_drained();
        snd_idle = 0;
        rcv_idle = 0;
        random_block(65);
        wait_results_drained();
    endtask

    // ---------------- result checking ----------------
    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        $display("MISMATCH %s at result %0d: got %h want %h", what, results_seen, got, want);
        err_cnt++;
    endtask

    always @(posedge i_clk) begin
        t_inv_elem e;
        if (i_rst_n && m_tvalid && m_tready) begin
            if (inverse_q.size() == 0) begin
                report_mismatch("unexpected item", m_tdata[35:4], 32'd0);
            end else begin
                e = inverse_q.pop_front();
                if (m_tdata[1:0] !== e.row)     report_mismatch("out_row", m_tdata[1:0], e.row);
                if (m_tdata[3:2] !== e.col)     report_mismatch("out_col", m_tdata[3:2], e.col);
                if (m_tdata[35:4] !== e.value)  report_mismatch("out_value", m_tdata[35:4], e.value);
                if (m_tdata[39:36] !== 4'd0)    report_mismatch("pad", m_tdata[39:36], 32'd0);
                if (m_tuser !== e.sing)         report_mismatch("singular", m_tuser, e.sing);
                if (m_tlast !== e.eom)          report_mismatch("end_of_matrix", m_tlast, e.eom);
            end
            results_seen++;
        end
        if (cycle < hold_until)
            m_tready <= 1'b0;
        else
            m_tready <= ($urandom_range(99, 0) >= rcv_idle);
    end

    // cycle count and timeout
    always @(posedge i_clk) begin
        cycle <= cycle + 1;
        if (cycle > CYC_LIMIT) begin
            $display("timeout after %0d cycles", cycle);
            $display("CHECKS FAILED");
            $finish;
        end
    end

    initial begin
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_backpressure();
        test_random();
        repeat (DRAIN_CYC) @(posedge i_clk);
        $display("Covered %0d items, %0d inversions (%0d singular), %0d results checked.",
                 items_sent, inversions, singular_cnt, results_seen);
        $display("Ties, extremes, zero pivots, backpressure and idle mixes exercised.");
        if (err_cnt == 0 && inverse_q.size() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
